@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

// consequent must hold after a delay that the dly argument sets, counted from the antecedent
`define ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) else $error(msg);

`endif

@@ hw/rtl/rdbt_pkg.sv @@
// Types shared by the controller and datapath of the bound test
package rdbt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIST,
    ST_SQR,
    ST_WGT,
    ST_MAX,
    ST_FRAC,
    ST_CEIL
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic acc_en;
    logic dist_en;
    logic sqr_en;
    logic wgt_en;
    logic max_en;
    logic frac_en;
    logic out_en;
  } cmd_t;

  typedef struct packed {
    logic row_close;
    logic set_close;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/rdbt_ctrl.sv @@
// Controller state machine sequencing one request through the datapath
module rdbt_ctrl import rdbt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = sts_i.row_close ? ST_DIST : ST_IDLE;
      ST_DIST: state_d = ST_SQR;
      ST_SQR:  state_d = ST_WGT;
      ST_WGT:  state_d = ST_MAX;
      ST_MAX:  state_d = sts_i.set_close ? ST_FRAC : ST_IDLE;
      ST_FRAC: state_d = ST_CEIL;
      ST_CEIL: begin
        // hold until the previous result has left the output register
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_MUL:  cmd_o.mul_en  = 1'b1;
      ST_ACC:  cmd_o.acc_en  = 1'b1;
      ST_DIST: cmd_o.dist_en = 1'b1;
      ST_SQR:  cmd_o.sqr_en  = 1'b1;
      ST_WGT:  cmd_o.wgt_en  = 1'b1;
      ST_MAX:  cmd_o.max_en  = 1'b1;
      ST_FRAC: cmd_o.frac_en = 1'b1;
      ST_CEIL: cmd_o.out_en  = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/rdbt_dp.sv @@
// Datapath: multiply-accumulate, rounding distance, running maximum and ceiling
module rdbt_dp import rdbt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [31:0] coord_i,
  input  logic signed [31:0] coeff_i,
  input  logic [31:0]        row_weight_i,
  input  logic               row_end_i,
  input  logic               set_end_i,
  input  logic [47:0]        lower_bound_i,
  input  logic               best_value_we_i,
  input  logic [31:0]        best_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               feasible_o,
  output logic [31:0]        bound_ceiling_o
);

  localparam int F2     = 2 * FRAC_BITS;
  localparam int SQ_W   = FRAC_BITS - 1;
  localparam int TERM_W = FRAC_BITS + 31;
  localparam int FS_W   = FRAC_BITS + 33;
  localparam int CV_W   = 49 - FRAC_BITS;
  localparam int CMP_W  = (CV_W > 32) ? CV_W : 32;

  logic signed [31:0] coord_q, coeff_q;
  logic [31:0]        weight_q;
  logic [47:0]        lb_q;
  logic               row_close_q, set_close_q;
  logic signed [63:0] prod_q, row_sum_q;
  logic [FRAC_BITS-1:0] dq_q;
  logic [SQ_W-1:0]    sq_q;
  logic [TERM_W-1:0]  term_q, max_term_q;
  logic [FS_W-1:0]    fs_q;
  logic [31:0]        best_value_q, ceil_q;
  logic               feasible_q, out_valid_q;

  logic signed [63:0] prod_d;
  logic [64:0]        sum_d;
  logic [63:0]        acc_d;
  logic [F2-1:0]      low_d, mag_d;
  logic [F2:0]        dist_d, rnd_d;
  logic [F2-1:0]      sqp_d;
  logic [CV_W-1:0]    ceil_d;
  logic [CMP_W-1:0]   cmp_d;

  assign prod_d = coord_q * coeff_q;

  // saturating accumulate: overflow when the two top sum bits disagree
  assign sum_d = {row_sum_q[63], row_sum_q} + {prod_q[63], prod_q};
  assign acc_d = (sum_d[64] ^ sum_d[63]) ? {sum_d[64], {63{~sum_d[64]}}} : sum_d[63:0];

  // only the fraction bits of |sum| matter
  assign low_d  = row_sum_q[F2-1:0];
  assign mag_d  = row_sum_q[63] ? (F2'(0) - low_d) : low_d;
  assign dist_d = mag_d[F2-1] ? (((F2+1)'(1) << F2) - {1'b0, mag_d}) : {1'b0, mag_d};
  assign rnd_d  = dist_d + ((F2+1)'(1) << (FRAC_BITS - 1));
  assign sqp_d  = dq_q * dq_q;

  assign ceil_d = CV_W'(lb_q[47:FRAC_BITS]) + CV_W'(fs_q[FS_W-1:F2]);
  assign cmp_d  = CMP_W'(ceil_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coord_q     <= coord_i;
      coeff_q     <= coeff_i;
      weight_q    <= row_weight_i;
      lb_q        <= lower_bound_i;
      row_close_q <= row_end_i | set_end_i;
      set_close_q <= set_end_i;
    end
    if (cmd_i.mul_en)  prod_q <= prod_d;
    if (cmd_i.dist_en) dq_q   <= rnd_d[F2-1:FRAC_BITS];
    if (cmd_i.sqr_en)  sq_q   <= sqp_d[F2-2:FRAC_BITS];
    if (cmd_i.wgt_en)  term_q <= TERM_W'(sq_q) * TERM_W'(weight_q);
    if (cmd_i.frac_en) begin
      fs_q <= FS_W'({lb_q[FRAC_BITS-1:0], FRAC_BITS'(0)}) + FS_W'(max_term_q)
            + FS_W'({F2{1'b1}});
    end
    if (cmd_i.out_en) begin
      feasible_q <= cmp_d < CMP_W'(best_value_q);
      ceil_q     <= (cmp_d > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cmp_d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q    <= '0;
      max_term_q   <= '0;
      best_value_q <= 32'hFFFF_FFFF;
      out_valid_q  <= 1'b0;
    end else begin
      if (best_value_we_i) best_value_q <= best_value_i;
      if (cmd_i.acc_en) begin
        row_sum_q <= acc_d;
      end else if (cmd_i.dist_en) begin
        row_sum_q <= '0;
      end
      if (cmd_i.max_en && (term_q > max_term_q)) begin
        max_term_q <= term_q;
      end else if (cmd_i.out_en) begin
        max_term_q <= '0;
      end
      if (cmd_i.out_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.row_close = row_close_q;
  assign sts_o.set_close = set_close_q;
  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign feasible_o      = feasible_q;
  assign bound_ceiling_o = ceil_q;

endmodule

@@ hw/rtl/rounding_distance_bound_test.sv @@
// Top level of the branch-and-bound rounding distance test
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | coord, coeff, row_weight, flags, bound
//  out     | output    | out_valid_o/out_ready_i | feasible, bound_ceiling
//  cfg     | input     | best_value_we_i         | best_value_i
//
// An element passes through load, multiply and accumulate; a row end adds distance,
// square, weight and maximum, and a set end adds the fraction sum and the ceiling.
// The shared controller runs one request at a time.
// Reset clears the accumulator, the maximum, the output valid; best_value returns to all ones.
// A held result stalls only the ceiling step; no new request is taken while it waits.
module rounding_distance_bound_test import rdbt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_i,
  input  logic signed [31:0] coeff_i,
  input  logic [31:0]        row_weight_i,
  input  logic               row_end_i,
  input  logic               set_end_i,
  input  logic [47:0]        lower_bound_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               feasible_o,
  output logic [31:0]        bound_ceiling_o,
  input  logic               best_value_we_i,
  input  logic [31:0]        best_value_i
);

  cmd_t cmd;
  sts_t sts;

  rdbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdbt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .coord_i         (coord_i),
    .coeff_i         (coeff_i),
    .row_weight_i    (row_weight_i),
    .row_end_i       (row_end_i),
    .set_end_i       (set_end_i),
    .lower_bound_i   (lower_bound_i),
    .best_value_we_i (best_value_we_i),
    .best_value_i    (best_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .feasible_o      (feasible_o),
    .bound_ceiling_o (bound_ceiling_o)
  );

endmodule

@@ hw/rtl/rdbt_checker.sv @@
// Port-level checks for the bound test, bound to the top level
`include "assert_macros.svh"

module rdbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        row_end_i,
  input logic        set_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        feasible_o,
  input logic [31:0] bound_ceiling_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(bound_ceiling_o), "stalled ceiling changed")
  `ASSERT_DELAY(a_elem_back, in_valid_i && in_ready_o && !row_end_i && !set_end_i, 3, in_ready_o, "plain element did not return to idle")
  `ASSERT_ALWAYS(a_feas_sat, !(out_valid_o && feasible_o && (bound_ceiling_o == 32'hFFFF_FFFF)), "feasible with saturated ceiling")

endmodule

bind rounding_distance_bound_test rdbt_checker u_rdbt_checker (.*);
